/* src/rbsi_pkg.sv */
// Package for the ray versus box slab intersection block.
// Holds widths, register indexes, the divider lane type and its step function.
// No dependencies.
package rbsi_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int VAL_W = 32;
    localparam int T_W = 31;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Z = 3'd5;

    localparam logic signed [31:0] T_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] T_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] nlo;
        logic [31:0] quo;
        logic        ovf;
        logic        neg;
    } lane_t;

    function automatic lane_t div_step(lane_t x, logic [31:0] den);
        logic [32:0] r2;
        logic        ge;
        lane_t       y;
        r2 = {x.rem, x.nlo[31]};
        ge = (r2 >= {1'b0, den});
        y = x;
        y.nlo = {x.nlo[30:0], 1'b0};
        y.quo = {x.quo[30:0], ge};
        y.rem = ge ? 32'(r2 - {1'b0, den}) : r2[31:0];
        return y;
    endfunction

endpackage

/* src/ray_in_if.sv */
// Channel carrying one ray: origin and direction, signed fixed point.
// Depends on nothing.
interface ray_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;

    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    input ready);
    modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  output ready);
endinterface

/* src/ray_out_if.sv */
// Channel carrying one intersection result: hit flag and the entry and exit distances.
// Depends on nothing.
interface ray_out_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [30:0] t_near;
    logic [30:0] t_far;

    modport source (output valid, hit, t_near, t_far, input ready);
    modport sink (input valid, hit, t_near, t_far, output ready);
endinterface

/* src/ray_box_slab_intersect.sv */
// Top level of the ray versus axis-aligned box slab intersection block.
// Uses rbsi_pkg and the interfaces ray_in_if and ray_out_if.
//
// Usage: write the six box bounds through cfg_we, cfg_index and cfg_data while the
// block is idle. Rays enter on the ray channel, one transfer per ray, and each ray
// gives exactly one result transfer on the res channel, in order.
// Each ray is carried to its result through 37 register
// stages: one stage forms the numerators, one stage checks for quotient overflow,
// 32 stages each retire one quotient bit in six parallel dividers, then one stage
// saturates, one orders each slab and the output register merges the intervals.
// Throughput is one ray per cycle. The whole pipeline advances together whenever
// the output register is empty or being taken, so a stalled receiver holds every
// stage in place and ray.ready drops in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and sets every box bound to zero.
// A ray with a zero direction on an axis misses when its origin lies outside that
// slab; otherwise that axis does not narrow the interval. On a miss both
// distances read zero.
module ray_box_slab_intersect #(
    parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rbsi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rbsi_pkg::VAL_W-1:0]     cfg_data,
    ray_in_if.sink                         ray,
    ray_out_if.source                      res
);
    import rbsi_pkg::*;

    localparam int NW = 33 + FRAC_BITS;
    localparam int CW = 66;
    localparam int STEPS = 32;

    logic signed [31:0] box_min_reg [3];
    logic signed [31:0] box_max_reg [3];

    logic adv;

    logic               a_vld_reg;
    logic [32:0]        a_num_reg [6];
    logic               a_neg_reg [6];
    logic [31:0]        a_den_reg [3];
    logic               a_zero_reg [3];
    logic               a_miss_reg;

    logic               b_vld_reg;
    lane_t              b_lane_reg [6];
    logic [31:0]        b_den_reg [3];
    logic               b_zero_reg [3];
    logic               b_miss_reg;

    logic               d_vld_reg [STEPS];
    lane_t              d_lane_reg [STEPS][6];
    logic [31:0]        d_den_reg [STEPS][3];
    logic               d_zero_reg [STEPS][3];
    logic               d_miss_reg [STEPS];

    logic               s_vld_reg;
    logic signed [31:0] s_t_reg [6];
    logic               s_zero_reg [3];
    logic               s_miss_reg;

    logic               o_vld_reg;
    logic signed [31:0] o_min_reg [3];
    logic signed [31:0] o_max_reg [3];
    logic               o_zero_reg [3];
    logic               o_miss_reg;

    logic               out_vld_reg;
    logic               out_hit_reg;
    logic [30:0]        out_near_reg;
    logic [30:0]        out_far_reg;

    logic signed [31:0] org [3];
    logic signed [31:0] dir [3];
    logic [32:0]        a_num_next [6];
    logic               a_neg_next [6];
    logic [31:0]        a_den_next [3];
    logic               a_zero_next [3];
    logic               a_miss_next;
    lane_t              b_lane_next [6];
    lane_t              d_lane_next [STEPS][6];
    logic signed [31:0] s_t_next [6];
    logic signed [31:0] o_min_next [3];
    logic signed [31:0] o_max_next [3];
    logic signed [31:0] lo_next;
    logic signed [31:0] hi_next;
    logic               out_hit_next;

    assign adv = !out_vld_reg || res.ready;
    assign ray.ready = adv;

    assign org[0] = ray.origin_x;
    assign org[1] = ray.origin_y;
    assign org[2] = ray.origin_z;
    assign dir[0] = ray.dir_x;
    assign dir[1] = ray.dir_y;
    assign dir[2] = ray.dir_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                box_min_reg[i] <= '0;
                box_max_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BOX_MIN_X: box_min_reg[0] <= cfg_data;
                REG_BOX_MIN_Y: box_min_reg[1] <= cfg_data;
                REG_BOX_MIN_Z: box_min_reg[2] <= cfg_data;
                REG_BOX_MAX_X: box_max_reg[0] <= cfg_data;
                REG_BOX_MAX_Y: box_max_reg[1] <= cfg_data;
                REG_BOX_MAX_Z: box_max_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        logic signed [32:0] diff;
        a_miss_next = 1'b0;
        for (int ax = 0; ax < 3; ax++)
        begin
            a_zero_next[ax] = (dir[ax] == '0);
            a_den_next[ax] = dir[ax][31] ? 32'(-dir[ax]) : dir[ax];
            if (a_zero_next[ax] && (org[ax] < box_min_reg[ax] || org[ax] > box_max_reg[ax]))
            begin
                a_miss_next = 1'b1;
            end
            for (int w = 0; w < 2; w++)
            begin
                diff = (w == 0) ? (33'(box_min_reg[ax]) - 33'(org[ax]))
                                : (33'(box_max_reg[ax]) - 33'(org[ax]));
                a_num_next[2*ax+w] = diff[32] ? 33'(-diff) : diff;
                a_neg_next[2*ax+w] = diff[32] ^ dir[ax][31];
            end
        end
    end

    always_comb
    begin
        logic [NW-1:0] num;
        for (int l = 0; l < 6; l++)
        begin
            num = {a_num_reg[l], FRAC_BITS'(0)};
            b_lane_next[l].rem = 32'(num[NW-1:32]);
            b_lane_next[l].nlo = num[31:0];
            b_lane_next[l].quo = '0;
            b_lane_next[l].ovf = (CW'(num) >= CW'({a_den_reg[l/2], 32'b0}));
            b_lane_next[l].neg = a_neg_reg[l];
        end
    end

    always_comb
    begin
        for (int l = 0; l < 6; l++)
        begin
            d_lane_next[0][l] = div_step(b_lane_reg[l], b_den_reg[l/2]);
            for (int k = 1; k < STEPS; k++)
            begin
                d_lane_next[k][l] = div_step(d_lane_reg[k-1][l], d_den_reg[k-1][l/2]);
            end
        end
    end

    always_comb
    begin
        lane_t x;
        for (int l = 0; l < 6; l++)
        begin
            x = d_lane_reg[STEPS-1][l];
            if (x.neg)
            begin
                s_t_next[l] = (x.ovf || x.quo > 32'h8000_0000) ? T_MIN : 32'(-x.quo);
            end
            else
            begin
                s_t_next[l] = (x.ovf || x.quo > 32'h7FFF_FFFF) ? T_MAX : x.quo;
            end
        end
    end

    always_comb
    begin
        for (int ax = 0; ax < 3; ax++)
        begin
            if (s_t_reg[2*ax] > s_t_reg[2*ax+1])
            begin
                o_min_next[ax] = s_t_reg[2*ax+1];
                o_max_next[ax] = s_t_reg[2*ax];
            end
            else
            begin
                o_min_next[ax] = s_t_reg[2*ax];
                o_max_next[ax] = s_t_reg[2*ax+1];
            end
        end
    end

    always_comb
    begin
        lo_next = '0;
        hi_next = T_MAX;
        for (int ax = 0; ax < 3; ax++)
        begin
            if (!o_zero_reg[ax])
            begin
                if (o_min_reg[ax] > lo_next)
                begin
                    lo_next = o_min_reg[ax];
                end
                if (o_max_reg[ax] < hi_next)
                begin
                    hi_next = o_max_reg[ax];
                end
            end
        end
        out_hit_next = !o_miss_reg && !(lo_next > hi_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            for (int k = 0; k < STEPS; k++)
            begin
                d_vld_reg[k] <= 1'b0;
            end
            s_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg <= ray.valid;
            b_vld_reg <= a_vld_reg;
            d_vld_reg[0] <= b_vld_reg;
            for (int k = 1; k < STEPS; k++)
            begin
                d_vld_reg[k] <= d_vld_reg[k-1];
            end
            s_vld_reg <= d_vld_reg[STEPS-1];
            o_vld_reg <= s_vld_reg;
            out_vld_reg <= o_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_num_reg <= a_num_next;
            a_neg_reg <= a_neg_next;
            a_den_reg <= a_den_next;
            a_zero_reg <= a_zero_next;
            a_miss_reg <= a_miss_next;

            b_lane_reg <= b_lane_next;
            b_den_reg <= a_den_reg;
            b_zero_reg <= a_zero_reg;
            b_miss_reg <= a_miss_reg;

            d_lane_reg[0] <= d_lane_next[0];
            d_den_reg[0] <= b_den_reg;
            d_zero_reg[0] <= b_zero_reg;
            d_miss_reg[0] <= b_miss_reg;
            for (int k = 1; k < STEPS; k++)
            begin
                d_lane_reg[k] <= d_lane_next[k];
                d_den_reg[k] <= d_den_reg[k-1];
                d_zero_reg[k] <= d_zero_reg[k-1];
                d_miss_reg[k] <= d_miss_reg[k-1];
            end

            s_t_reg <= s_t_next;
            s_zero_reg <= d_zero_reg[STEPS-1];
            s_miss_reg <= d_miss_reg[STEPS-1];

            o_min_reg <= o_min_next;
            o_max_reg <= o_max_next;
            o_zero_reg <= s_zero_reg;
            o_miss_reg <= s_miss_reg;

            out_hit_reg <= out_hit_next;
            out_near_reg <= out_hit_next ? lo_next[30:0] : '0;
            out_far_reg <= out_hit_next ? hi_next[30:0] : '0;
        end
    end

    assign res.valid = out_vld_reg;
    assign res.hit = out_hit_reg;
    assign res.t_near = out_near_reg;
    assign res.t_far = out_far_reg;

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.hit) |-> (res.t_near == '0 && res.t_far == '0))
        else $error("miss result carries nonzero distances");

    a_hit_order: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.hit) |-> (res.t_near <= res.t_far))
        else $error("hit result with entry beyond exit");

    a_sat_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (o_vld_reg && o_miss_reg && adv) |=> !out_hit_reg)
        else $error("zero-direction miss lost in the pipeline");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        o_vld_reg |-> (o_min_reg[0] <= o_max_reg[0] && o_min_reg[1] <= o_max_reg[1]
                       && o_min_reg[2] <= o_max_reg[2]))
        else $error("slab crossings not ordered");

endmodule

/* tb/testbench.sv */
// Testbench for ray_box_slab_intersect: random and directed rays against configured boxes.
// Predicts each result with a local slab-method model and checks every result transfer.
// Depends on rbsi_pkg, ray_in_if and ray_out_if.
`timescale 1ns / 1ps

module testbench;
    import rbsi_pkg::*;

    localparam int LATENCY = 37;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] oz;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] dz;
    } ray_t;

    typedef struct packed {
        logic        hit;
        logic [30:0] t_near;
        logic [30:0] t_far;
    } hit_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [VAL_W-1:0] cfg_data = '0;

    ray_in_if ray ();
    ray_out_if res ();

    ray_box_slab_intersect u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .ray(ray.sink), .res(res.source)
    );

    always #4 clk = ~clk;

    ray_t pending_rays[$];
    hit_t expected_hits[$];
    logic signed [31:0] box_lo[3];
    logic signed [31:0] box_hi[3];
    int src_idle_pct = 0;
    int dst_stall_pct = 0;
    int errors = 0;
    int idle_cycles = 0;

    initial
    begin
        ray.valid = 1'b0;
        ray.origin_x = '0;
        ray.origin_y = '0;
        ray.origin_z = '0;
        ray.dir_x = '0;
        ray.dir_y = '0;
        ray.dir_z = '0;
        res.ready = 1'b0;
    end

    function automatic logic signed [63:0] slab_div(logic signed [63:0] num,
                                                   logic signed [63:0] den);
        logic neg;
        logic [63:0] n;
        logic [63:0] d;
        logic [63:0] q;
        neg = (num < 0) != (den < 0);
        n = num < 0 ? -num : num;
        d = den < 0 ? -den : den;
        q = (n << 16) / d;
        if (neg)
        begin
            if (q > 64'h8000_0000)
                q = 64'h8000_0000;
            return -$signed(q);
        end
        if (q > 64'h7FFF_FFFF)
            q = 64'h7FFF_FFFF;
        return $signed(q);
    endfunction

    function automatic hit_t predict_hit(ray_t r);
        logic signed [63:0] lo;
        logic signed [63:0] hi;
        logic signed [63:0] o;
        logic signed [63:0] d;
        logic signed [63:0] t1;
        logic signed [63:0] t2;
        logic signed [63:0] tmp;
        logic miss;
        hit_t h;
        lo = 0;
        hi = 64'h7FFF_FFFF;
        miss = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            o = (i == 0) ? r.ox : (i == 1) ? r.oy : r.oz;
            d = (i == 0) ? r.dx : (i == 1) ? r.dy : r.dz;
            if (d == 0)
            begin
                if (o < box_lo[i] || o > box_hi[i])
                    miss = 1'b1;
            end
            else
            begin
                t1 = slab_div(box_lo[i] - o, d);
                t2 = slab_div(box_hi[i] - o, d);
                if (t1 > t2)
                begin
                    tmp = t1;
                    t1 = t2;
                    t2 = tmp;
                end
                if (t1 > lo)
                    lo = t1;
                if (t2 < hi)
                    hi = t2;
            end
        end
        if (miss || lo > hi)
            h = '0;
        else
        begin
            h.hit = 1'b1;
            h.t_near = lo[30:0];
            h.t_far = hi[30:0];
        end
        return h;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    // Driver: valid stays high across back-to-back transfers.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!ray.valid || ray.ready)
            begin
                if (pending_rays.size() > 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    ray_t r;
                    r = pending_rays.pop_front();
                    ray.valid <= 1'b1;
                    ray.origin_x <= r.ox;
                    ray.origin_y <= r.oy;
                    ray.origin_z <= r.oz;
                    ray.dir_x <= r.dx;
                    ray.dir_y <= r.dy;
                    ray.dir_z <= r.dz;
                    expected_hits.push_back(predict_hit(r));
                end
                else
                    ray.valid <= 1'b0;
            end
            res.ready <= ($urandom_range(99) >= dst_stall_pct);
        end
    end

    // Monitor and watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((ray.valid && ray.ready) || (res.valid && res.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
            if (res.valid && res.ready)
            begin
                if (expected_hits.size() == 0)
                begin
                    report_mismatch("unexpected result", 32'(res.hit), 32'h0);
                end
                else
                begin
                    hit_t w;
                    w = expected_hits.pop_front();
                    if (res.hit !== w.hit)
                        report_mismatch("hit", 32'(res.hit), 32'(w.hit));
                    if (res.t_near !== w.t_near)
                        report_mismatch("t_near", 32'(res.t_near), 32'(w.t_near));
                    if (res.t_far !== w.t_far)
                        report_mismatch("t_far", 32'(res.t_far), 32'(w.t_far));
                end
            end
        end
    end

    task automatic write_box(logic signed [31:0] lo[3], logic signed [31:0] hi[3]);
        for (int i = 0; i < 6; i++)
        begin
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_index <= i[CFG_IDX_W-1:0];
            cfg_data <= (i < 3) ? lo[i] : hi[i - 3];
            if (i < 3)
                box_lo[i] = lo[i];
            else
                box_hi[i - 3] = hi[i - 3];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_rays.size() > 0 || expected_hits.size() > 0 || ray.valid)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_val();
        case ($urandom_range(5))
            0: return $urandom();
            1: return $urandom_range(8) == 0 ? 32'h0 : $urandom() & 32'h000F_FFFF;
            2: return -($urandom() & 32'h000F_FFFF);
            3: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            4: return $urandom_range(1) ? 32'h0000_0001 : 32'hFFFF_FFFF;
            default: return ($urandom() & 32'h003F_FFFF) - 32'h0020_0000;
        endcase
    endfunction

    function automatic ray_t rand_ray();
        ray_t r;
        r.ox = rand_val();
        r.oy = rand_val();
        r.oz = rand_val();
        r.dx = ($urandom_range(7) == 0) ? 32'sh0 : rand_val();
        r.dy = ($urandom_range(7) == 0) ? 32'sh0 : rand_val();
        r.dz = ($urandom_range(7) == 0) ? 32'sh0 : rand_val();
        return r;
    endfunction

    initial
    begin
        logic signed [31:0] lo[3];
        logic signed [31:0] hi[3];
        ray_t r;
        int phase_pct[4][2];
        phase_pct = '{'{0, 0}, '{55, 0}, '{0, 55}, '{23, 23}};
        for (int i = 0; i < 3; i++)
        begin
            box_lo[i] = 0;
            box_hi[i] = 0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        lo = '{-32'sh10000, -32'sh10000, -32'sh10000};
        hi = '{32'sh10000, 32'sh10000, 32'sh10000};
        write_box(lo, hi);
        r = '{32'sh0, 32'sh0, -32'sh50000, 32'sh0, 32'sh0, 32'sh10000};
        pending_rays.push_back(r);
        r = '{32'sh20000, 32'sh0, -32'sh50000, 32'sh0, 32'sh0, 32'sh10000};
        pending_rays.push_back(r);
        r = '{32'sh0, 32'sh0, 32'sh50000, 32'sh0, 32'sh0, 32'sh10000};
        pending_rays.push_back(r);
        r = '{32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0};
        pending_rays.push_back(r);
        r = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000,
              32'sh80000000};
        pending_rays.push_back(r);
        r = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh1, 32'sh1, 32'sh1};
        pending_rays.push_back(r);
        r = '{32'sh0, 32'sh0, 32'sh0, 32'sh7FFFFFFF, 32'sh1, 32'shFFFFFFFF};
        pending_rays.push_back(r);
        r = '{-32'sh30000, 32'sh5000, 32'sh5000, 32'sh10000, 32'sh8000, -32'sh8000};
        pending_rays.push_back(r);
        r = '{32'sh10000, 32'sh10000, 32'sh10000, -32'sh1, 32'sh0, 32'sh0};
        pending_rays.push_back(r);
        wait_drained();

        // Inverted box on x, extreme bounds on y and z.
        lo = '{32'sh10000, 32'sh80000000, 32'sh80000000};
        hi = '{-32'sh10000, 32'sh7FFFFFFF, 32'sh7FFFFFFF};
        write_box(lo, hi);
        r = '{32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh10000, 32'sh10000};
        pending_rays.push_back(r);
        r = '{-32'sh50000, 32'sh0, 32'sh0, 32'sh10000, 32'sh0, 32'sh0};
        pending_rays.push_back(r);
        r = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh0, 32'sh80000000, 32'sh7FFFFFFF,
              32'sh0};
        pending_rays.push_back(r);
        wait_drained();

        for (int p = 0; p < 8; p++)
        begin
            src_idle_pct = phase_pct[p % 4][0];
            dst_stall_pct = phase_pct[p % 4][1];
            for (int i = 0; i < 3; i++)
            begin
                lo[i] = (p == 7) ? 32'sh80000000 : -($urandom() & 32'h003F_FFFF);
                hi[i] = (p == 7) ? 32'sh7FFFFFFF : ($urandom() & 32'h003F_FFFF);
                if ($urandom_range(9) == 0)
                    lo[i] = $urandom();
            end
            write_box(lo, hi);
            for (int n = 0; n < 125; n++)
                pending_rays.push_back(rand_ray());
            wait_drained();
        end

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

/* filelist.f */
src/rbsi_pkg.sv
src/ray_in_if.sv
src/ray_out_if.sv
src/ray_box_slab_intersect.sv
tb/testbench.sv
